FILE: hw/rtl/mbpc_pkg.sv
// ----------------------------------------------------------------------------
// mbpc_pkg
// Shared types and constants for the multi-button press classifier.
// ----------------------------------------------------------------------------
package mbpc_pkg;

   // field widths fixed by the interface
   localparam int PRESS_W  = 8;
   localparam int MODE_W   = 8;
   localparam int CODES_W  = 16;
   localparam int CODE_W   = 2;
   localparam int THR_W    = 16;
   localparam int CSR_IDX_W = 8;

   // most lanes that can reach the code vector
   localparam int MAX_LANES = CODES_W / CODE_W;

   // parameter defaults
   localparam int BUTTONS_DEF  = 8;
   localparam int CNT_BITS_DEF = 16;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_THR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_LONG_THR  = CSR_IDX_W'(1);

   localparam logic [THR_W-1:0] SHORT_THR_RST = THR_W'(50);
   localparam logic [THR_W-1:0] LONG_THR_RST  = THR_W'(500);

   // press modes
   localparam logic [MODE_W-1:0] MODE_SHORT_A = MODE_W'(8'h00);
   localparam logic [MODE_W-1:0] MODE_SHORT_B = MODE_W'(8'h01);
   localparam logic [MODE_W-1:0] MODE_LONG_A  = MODE_W'(8'h02);
   localparam logic [MODE_W-1:0] MODE_LONG_B  = MODE_W'(8'h03);

   // request codes
   localparam logic [CODE_W-1:0] CODE_IDLE  = 2'h0;
   localparam logic [CODE_W-1:0] CODE_SHORT = 2'h1;
   localparam logic [CODE_W-1:0] CODE_LONG  = 2'h2;
   localparam logic [CODE_W-1:0] CODE_STUCK = 2'h3;

   typedef enum logic [1:0] {
      PH_POLL  = 2'd0,
      PH_SHORT = 2'd1,
      PH_LONG  = 2'd2,
      PH_STUCK = 2'd3
   } phase_type;

   typedef struct packed {
      logic [THR_W-1:0] short_thr;
      logic [THR_W-1:0] long_thr;
   } thr_cfg_type;

endpackage

FILE: hw/rtl/mbpc_lane.sv
// ----------------------------------------------------------------------------
// mbpc_lane
// One button: phase machine, hold counter and last request code.
// ----------------------------------------------------------------------------
module mbpc_lane
   import mbpc_pkg::*;
#(
   parameter int COUNTER_BITS = CNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              held,
   input  logic [MODE_W-1:0] mode,
   input  thr_cfg_type       cfg,
   output logic [CODE_W-1:0] code_next
);

   localparam int CMP_W = (COUNTER_BITS > THR_W) ? COUNTER_BITS : THR_W;

   phase_type               phase_ff, phase_in;
   logic [COUNTER_BITS-1:0] count_ff, count_in;
   logic [CODE_W-1:0]       code_ff, code_in;

   logic [COUNTER_BITS-1:0] count_inc;
   logic [CMP_W-1:0]        count_ext;
   logic                    below_short;
   logic                    below_long;
   logic                    mode_short;
   logic                    mode_long;

   assign count_inc   = count_ff + COUNTER_BITS'(1);
   assign count_ext   = CMP_W'(count_inc);
   assign below_short = count_ext < CMP_W'(cfg.short_thr);
   assign below_long  = count_ext < CMP_W'(cfg.long_thr);
   assign mode_short  = (mode == MODE_SHORT_A) || (mode == MODE_SHORT_B);
   assign mode_long   = (mode == MODE_LONG_A) || (mode == MODE_LONG_B);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      code_in  = code_ff;
      unique case (phase_ff)
         PH_POLL: begin
            if (held && mode_short) begin
               phase_in = PH_SHORT;
            end else if (held && mode_long) begin
               phase_in = PH_LONG;
            end
         end
         PH_SHORT: begin
            count_in = count_inc;
            code_in  = CODE_IDLE;
            if (!below_short) begin
               phase_in = PH_LONG;
            end else if (!held) begin
               code_in  = CODE_SHORT;
               count_in = '0;
               phase_in = PH_POLL;
            end
         end
         PH_LONG: begin
            count_in = count_inc;
            code_in  = CODE_IDLE;
            if (!below_long) begin
               count_in = '0;
               if (held) begin
                  code_in  = CODE_STUCK;
                  phase_in = PH_STUCK;
               end else begin
                  phase_in = PH_POLL;
               end
            end else if (held) begin
               code_in = CODE_LONG;
            end else begin
               count_in = '0;
               phase_in = PH_POLL;
            end
         end
         PH_STUCK: begin
            code_in = CODE_STUCK;
         end
         default: begin
            phase_in = PH_POLL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_POLL;
         count_ff <= '0;
         code_ff  <= CODE_IDLE;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         code_ff  <= code_in;
      end
   end

   assign code_next = code_in;

`ifndef SYNTHESIS
   a_stuck_holds: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_STUCK |=> phase_ff == PH_STUCK)
      else $error("lane left stuck phase");

   a_poll_count_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_POLL |-> count_ff == '0)
      else $error("hold counter not cleared while polling");

   a_stuck_code: assert property (@(posedge clock) disable iff (reset)
      (code_ff == CODE_STUCK) == (phase_ff == PH_STUCK))
      else $error("stuck code out of step with phase");
`endif

endmodule

FILE: hw/rtl/mbpc_merge.sv
// ----------------------------------------------------------------------------
// mbpc_merge
// Packs the lane codes into one word and buffers it in an output register
// with a skid stage.
// ----------------------------------------------------------------------------
module mbpc_merge
   import mbpc_pkg::*;
#(
   parameter int LANES = MAX_LANES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [LANES-1:0][CODE_W-1:0]  codes,
   output logic                          full,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CODES_W-1:0]            rsp_request_codes
);

   logic [CODES_W-1:0] packed_word;
   logic               out_valid_ff, out_valid_in;
   logic [CODES_W-1:0] out_data_ff, out_data_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [CODES_W-1:0] skid_data_ff, skid_data_in;
   logic               take;

   always_comb begin
      packed_word = '0;
      for (int i = 0; i < LANES; i++) begin
         packed_word[CODE_W*i +: CODE_W] = codes[i];
      end
   end

   assign take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || take) begin
         // no push arrives while the skid word is held
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_data_in  = packed_word;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_data_in  = packed_word;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full              = skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_request_codes = out_data_ff;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output register");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall && push))
      else $error("skid filled without a stalled output");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push && !out_valid_ff |=> out_valid_ff && !skid_valid_ff)
      else $error("word pushed into empty buffer did not land");
`endif

endmodule

FILE: hw/rtl/multi_button_press_classifier.sv
// ----------------------------------------------------------------------------
// multi_button_press_classifier
// Per-button short/long/stuck press classifier, one lane per button, codes
// merged into one packed word per tick.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_button_pressed, req_press_mode
//   rsp     | out       | rsp_valid / rsp_stall | rsp_request_codes
//   csr     | in        | csr_write_enable      | csr_index, csr_write_data
//
// One word per cycle while req_stall is low: every lane updates its phase and
// counter in the cycle the word is taken, and the packed codes are registered
// in a two-entry output buffer (register plus skid) before they reach rsp; the
// buffer keeps req moving while rsp stalls, and req_stall rises only once both
// are full. Synchronous reset puts every lane in polling with a zero counter
// and idle code, and loads the threshold reset values.
// ----------------------------------------------------------------------------
module multi_button_press_classifier
   import mbpc_pkg::*;
#(
   parameter int BUTTONS      = BUTTONS_DEF,
   parameter int COUNTER_BITS = CNT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PRESS_W-1:0]   req_button_pressed,
   input  logic [MODE_W-1:0]    req_press_mode,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CODES_W-1:0]   rsp_request_codes,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [THR_W-1:0]     csr_write_data
);

   // buttons past the code vector never reach the output
   localparam int LANES = (BUTTONS < MAX_LANES) ? BUTTONS : MAX_LANES;

   thr_cfg_type                 cfg_ff, cfg_in;
   logic                        accept;
   logic                        full;
   logic [LANES-1:0][CODE_W-1:0] lane_codes;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         if (csr_index == REG_SHORT_THR) begin
            cfg_in.short_thr = csr_write_data;
         end else if (csr_index == REG_LONG_THR) begin
            cfg_in.long_thr = csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_thr <= SHORT_THR_RST;
         cfg_ff.long_thr  <= LONG_THR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !full;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      mbpc_lane #(
         .COUNTER_BITS (COUNTER_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .step      (accept),
         .held      (req_button_pressed[i]),
         .mode      (req_press_mode),
         .cfg       (cfg_ff),
         .code_next (lane_codes[i])
      );
   end

   mbpc_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock             (clock),
      .reset             (reset),
      .push              (accept),
      .codes             (lane_codes),
      .full              (full),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_request_codes (rsp_request_codes)
   );

endmodule

FILE: tb/multi_button_press_classifier_tb.sv
// ----------------------------------------------------------------------------
// multi_button_press_classifier_tb
// Self-checking bench for the press classifier. A short table of hand-made
// words covers the phase paths, unmapped register writes and zero and maximum
// thresholds, followed by random press sequences under several threshold
// settings. Returned vectors are checked against a lane-by-lane software copy
// of the classifier or a row's typed codes. Both sides idle at random.
// ----------------------------------------------------------------------------
module multi_button_press_classifier_tb;
   import mbpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SPARE_LANES     = 6;       // lanes kept out of stuck in long runs
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int MAX_GAP         = 17;

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_HI = '1;

   typedef enum bit {ROW_WORD, ROW_CSR} row_kind_type;

   // a is the pressed mask or the register index, b the mode or the write data
   typedef struct {
      row_kind_type       kind;
      logic [7:0]         a;
      logic [15:0]        b;
      bit                 typed;
      logic [CODES_W-1:0] codes;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PRESS_W-1:0]   req_button_pressed = '0;
   logic [MODE_W-1:0]    req_press_mode = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CODES_W-1:0]   rsp_request_codes;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [THR_W-1:0]     csr_write_data = '0;

   // classifier copy
   thr_cfg_type             model_cfg;
   phase_type               lane_phase [BUTTONS_DEF];
   logic [CNT_BITS_DEF-1:0] lane_count [BUTTONS_DEF];
   logic [CODE_W-1:0]       lane_code  [BUTTONS_DEF];

   logic [CODES_W-1:0] codes_due [$];
   stim_row_type       steps [$];
   int                 press_left [BUTTONS_DEF];

   int idle_max = MAX_GAP;
   int words_sent;
   int codes_checked;
   int csr_writes;
   int mismatch_count;
   int cycle_count;
   int hold_off_asks;
   int hold_off_seen;
   int hold_left;
   int stall_left;
   logic [CODES_W-1:0] want_codes;

   multi_button_press_classifier u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_button_pressed (req_button_pressed),
      .req_press_mode     (req_press_mode),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_request_codes  (rsp_request_codes),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d codes still due", cycle_count, codes_due.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // one tick of every lane; returns the packed code vector
   function automatic logic [CODES_W-1:0] classify_tick(logic [PRESS_W-1:0] pressed,
                                                        logic [MODE_W-1:0] mode);
      logic [CODES_W-1:0] codes;
      logic held;
      int l;
      codes = '0;
      for (l = 0; l < BUTTONS_DEF; l++) begin
         held = pressed[l];
         case (lane_phase[l])
            PH_POLL: begin
               if (held) begin
                  if (mode == MODE_SHORT_A || mode == MODE_SHORT_B)
                     lane_phase[l] = PH_SHORT;
                  else if (mode == MODE_LONG_A || mode == MODE_LONG_B)
                     lane_phase[l] = PH_LONG;
               end
            end
            PH_SHORT: begin
               lane_count[l] = lane_count[l] + 1'b1;
               if (lane_count[l] < model_cfg.short_thr) begin
                  if (held) begin
                     lane_code[l] = CODE_IDLE;
                  end else begin
                     lane_code[l]  = CODE_SHORT;
                     lane_count[l] = '0;
                     lane_phase[l] = PH_POLL;
                  end
               end else begin
                  // counter keeps running into the long phase
                  lane_code[l]  = CODE_IDLE;
                  lane_phase[l] = PH_LONG;
               end
            end
            PH_LONG: begin
               lane_count[l] = lane_count[l] + 1'b1;
               if (lane_count[l] < model_cfg.long_thr) begin
                  if (held) begin
                     lane_code[l] = CODE_LONG;
                  end else begin
                     lane_code[l]  = CODE_IDLE;
                     lane_count[l] = '0;
                     lane_phase[l] = PH_POLL;
                  end
               end else begin
                  lane_count[l] = '0;
                  if (held) begin
                     lane_code[l]  = CODE_STUCK;
                     lane_phase[l] = PH_STUCK;
                  end else begin
                     lane_code[l]  = CODE_IDLE;
                     lane_phase[l] = PH_POLL;
                  end
               end
            end
            default: begin
               lane_code[l] = CODE_STUCK;
            end
         endcase
         codes[CODE_W*l +: CODE_W] = lane_code[l];
      end
      return codes;
   endfunction

   // release the low lanes on the tick on which they would latch stuck
   function automatic logic [PRESS_W-1:0] spare_lanes(logic [PRESS_W-1:0] pressed);
      logic [PRESS_W-1:0] kept;
      logic [CNT_BITS_DEF-1:0] next_count;
      int l;
      kept = pressed;
      for (l = 0; l < SPARE_LANES; l++) begin
         next_count = lane_count[l] + 1'b1;
         if (lane_phase[l] == PH_LONG && next_count >= model_cfg.long_thr)
            kept[l] = 1'b0;
      end
      return kept;
   endfunction

   task automatic send_word(input logic [PRESS_W-1:0] pressed, input logic [MODE_W-1:0] mode,
                            input bit typed, input logic [CODES_W-1:0] typed_codes);
      int gap;
      logic [CODES_W-1:0] predicted;
      gap = $urandom_range(0, idle_max);
      csr_write_enable <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_button_pressed <= pressed;
      req_press_mode     <= mode;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = classify_tick(pressed, mode);
      codes_due.push_back(typed ? typed_codes : predicted);
      words_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (codes_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
      wait_for_drain();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      if (idx == REG_SHORT_THR)
         model_cfg.short_thr = data;
      else if (idx == REG_LONG_THR)
         model_cfg.long_thr = data;
      csr_writes++;
   endtask

   // random press runs per lane with a shared mode, some noise words mixed in
   task automatic run_random_phase(input logic [THR_W-1:0] short_thr,
                                   input logic [THR_W-1:0] long_thr,
                                   input int gap_limit, input int words, input bit squeeze);
      logic [PRESS_W-1:0] pressed;
      logic [MODE_W-1:0] mode;
      int span;
      int n;
      int l;
      write_reg(REG_SHORT_THR, short_thr);
      write_reg(REG_LONG_THR, long_thr);
      idle_max = gap_limit;
      span = int'(short_thr) + int'(long_thr) + 3;
      if (span > 40)
         span = 40;
      for (n = 0; n < words; n++) begin
         for (l = 0; l < BUTTONS_DEF; l++) begin
            if (press_left[l] == 0 && $urandom_range(0, 3) == 0)
               press_left[l] = $urandom_range(1, span);
            pressed[l] = (press_left[l] > 0);
            if (press_left[l] > 0)
               press_left[l]--;
         end
         if ($urandom_range(0, 9) < 8)
            mode = MODE_W'($urandom_range(0, 3));
         else
            mode = MODE_W'($urandom());
         if ($urandom_range(0, 11) == 0)
            pressed = PRESS_W'($urandom());
         if (squeeze && n == words / 4)
            hold_off_asks++;
         if (squeeze && n == 3 * words / 4)
            wait_for_drain();
         send_word(spare_lanes(pressed), mode, 1'b0, '0);
      end
   endtask

   // result side: random stalls per word, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (codes_due.size() == 0) begin
               $error("request_codes: word with nothing expected, got %h", rsp_request_codes);
               mismatch_count++;
            end else begin
               want_codes = codes_due.pop_front();
               if (want_codes !== rsp_request_codes) begin
                  $error("request_codes: expected %h, got %h", want_codes, rsp_request_codes);
                  mismatch_count++;
               end
               codes_checked++;
            end
            stall_left = $urandom_range(0, idle_max);
         end
         if (hold_off_asks != hold_off_seen) begin
            hold_off_seen = hold_off_asks;
            hold_left     = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int l;
      model_cfg.short_thr = SHORT_THR_RST;
      model_cfg.long_thr  = LONG_THR_RST;
      for (l = 0; l < BUTTONS_DEF; l++) begin
         lane_phase[l] = PH_POLL;
         lane_count[l] = '0;
         lane_code[l]  = CODE_IDLE;
         press_left[l] = 0;
      end

      // directed words: short and long paths, stuck latch, ignored modes,
      // unmapped registers, zero and full-scale thresholds
      steps.push_back('{ROW_WORD, 8'h00, 16'(MODE_SHORT_A), 1'b1, 16'h0000});
      steps.push_back('{ROW_CSR,  REG_SHORT_THR, 16'd2, 1'b0, 16'h0});
      steps.push_back('{ROW_CSR,  REG_LONG_THR, 16'd4, 1'b0, 16'h0});
      steps.push_back('{ROW_CSR,  REG_UNMAPPED_LO, 16'hFFFF, 1'b0, 16'h0});
      steps.push_back('{ROW_CSR,  REG_UNMAPPED_HI, 16'h0000, 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h01, 16'(MODE_SHORT_A), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h00, 16'(MODE_SHORT_A), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h02, 16'(MODE_LONG_A), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h02, 16'(MODE_LONG_A), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h00, 16'(MODE_LONG_A), 1'b0, 16'h0});
      // short hold that runs past the short threshold into long
      steps.push_back('{ROW_WORD, 8'h40, 16'(MODE_SHORT_B), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h40, 16'(MODE_SHORT_B), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h40, 16'(MODE_SHORT_B), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h40, 16'(MODE_SHORT_B), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h00, 16'(MODE_SHORT_B), 1'b0, 16'h0});
      // top lane held until stuck, then released
      steps.push_back('{ROW_WORD, 8'h80, 16'(MODE_LONG_B), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h80, 16'(MODE_LONG_B), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h80, 16'(MODE_LONG_B), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h80, 16'(MODE_LONG_B), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h80, 16'(MODE_LONG_B), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h00, 16'(MODE_LONG_B), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'hFF, 16'h00FF, 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'hFF, 16'(MODE_SHORT_A), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h00, 16'(MODE_SHORT_A), 1'b1, 16'hD555});
      steps.push_back('{ROW_CSR,  REG_SHORT_THR, 16'h0000, 1'b0, 16'h0});
      steps.push_back('{ROW_CSR,  REG_LONG_THR, 16'h0000, 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h0F, 16'(MODE_LONG_A), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h00, 16'(MODE_LONG_A), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h30, 16'(MODE_SHORT_A), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h30, 16'(MODE_SHORT_A), 1'b0, 16'h0});
      steps.push_back('{ROW_WORD, 8'h00, 16'(MODE_SHORT_A), 1'b0, 16'h0});
      steps.push_back('{ROW_CSR,  REG_SHORT_THR, 16'hFFFF, 1'b0, 16'h0});
      steps.push_back('{ROW_CSR,  REG_LONG_THR, 16'hFFFF, 1'b0, 16'h0});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         if (steps[i].kind == ROW_CSR)
            write_reg(steps[i].a, steps[i].b);
         else
            send_word(steps[i].a, steps[i].b[MODE_W-1:0], steps[i].typed, steps[i].codes);
      end

      run_random_phase(16'd3, 16'd8, MAX_GAP, 118, 1'b1);
      run_random_phase(16'd1, 16'd1, MAX_GAP, 118, 1'b0);
      run_random_phase(16'd6, 16'd25, 0, 118, 1'b0);
      run_random_phase(16'hFFFF, 16'hFFFF, MAX_GAP, 118, 1'b0);
      run_random_phase(16'd10, 16'd30, MAX_GAP, 118, 1'b1);
      run_random_phase(16'd2, 16'd5, MAX_GAP, 118, 1'b0);

      wait_for_drain();
      repeat (4) @(posedge clock);
      if (codes_due.size() != 0) begin
         $error("request_codes: %0d code vectors never returned", codes_due.size());
         mismatch_count++;
      end

      $display("run covered %0d words under six threshold settings, %0d register writes",
               words_sent, csr_writes);
      $display("%0d code vectors compared, %0d mismatches", codes_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/mbpc_pkg.sv
hw/rtl/mbpc_lane.sv
hw/rtl/mbpc_merge.sv
hw/rtl/multi_button_press_classifier.sv
tb/multi_button_press_classifier_tb.sv
